FILE: rtl/tbbw_pkg.sv
// shared types, constants and codes of the tapered block bootstrap weight engine
`default_nettype none

package tbbw_pkg;

   // default store depth
   localparam int unsigned MAX_SAMPLES_DEF = 4096;

   // field widths
   localparam int unsigned CNT_W   = 13;
   localparam int unsigned SUM_W   = 29;
   localparam int unsigned FREQ_W  = 17;
   localparam int unsigned POS_W   = 12;
   localparam int unsigned LEN_W   = 13;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned BLK_W   = 32;

   // datapath widths
   localparam int unsigned LIM_W   = LEN_W + 1 + FRAC_W;
   localparam int unsigned NUM_W   = LIM_W;
   localparam int unsigned DEN_W   = BLK_W + SUM_W;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPER_FRACTION = 2'd2;

   // register reset values
   localparam logic [LEN_W-1:0]  SAMPLE_COUNT_RST   = 13'd4096;
   localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RST   = 13'd1;
   localparam logic [FRAC_W-1:0] TAPER_FRACTION_RST = 16'd32768;

   // operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // saturation limits
   localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [FREQ_W-1:0] ONE_Q16   = 17'h10000;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_LMUL,
      ST_LSET,
      ST_IDLE,
      ST_WEVAL,
      ST_WDIV,
      ST_WUSE,
      ST_RREAD,
      ST_RDEN,
      ST_RDIV1,
      ST_RDEN2,
      ST_RDIV2,
      ST_OUT
   } tbbw_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_SAT,
      DV_STEP,
      DV_DONE
   } div_state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] quot;
   } div_out_type;

endpackage

`default_nettype wire

FILE: rtl/tbbw_div.sv
// shared restoring divider: num * 2^16 / den, saturated at one in q.16
`default_nettype none

module tbbw_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tbbw_pkg::div_req_type req,
   output tbbw_pkg::div_out_type     rsp
);

   localparam int unsigned REM_W  = tbbw_pkg::DEN_W + 1;
   localparam int unsigned STEP_W = $clog2(tbbw_pkg::FREQ_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(tbbw_pkg::FREQ_W - 1);

   tbbw_pkg::div_state_type state_ff, state_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [tbbw_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [tbbw_pkg::FREQ_W-1:0]   quot_ff, quot_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [REM_W-1:0]              sub_b;
   logic [REM_W:0]                diff;
   logic                          ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbbw_pkg::DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   // one compare and subtract, shared by the overflow check and the steps
   assign sub_b = (state_ff == tbbw_pkg::DV_SAT) ? {den_ff, 1'b0} : {1'b0, den_ff};
   assign diff  = {1'b0, rem_ff} - {1'b0, sub_b};
   assign ge    = ~diff[REM_W];

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      case (state_ff)
         tbbw_pkg::DV_IDLE: begin
            state_in = tbbw_pkg::DV_IDLE;
         end
         tbbw_pkg::DV_SAT: begin
            // num >= 2*den means the quotient is at least two
            if (ge) begin
               quot_in  = tbbw_pkg::ONE_Q16;
               state_in = tbbw_pkg::DV_DONE;
            end else begin
               quot_in  = '0;
               step_in  = '0;
               state_in = tbbw_pkg::DV_STEP;
            end
         end
         tbbw_pkg::DV_STEP: begin
            if (ge) begin
               rem_in  = {diff[REM_W-2:0], 1'b0};
               quot_in = {quot_ff[tbbw_pkg::FREQ_W-2:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[REM_W-2:0], 1'b0};
               quot_in = {quot_ff[tbbw_pkg::FREQ_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = tbbw_pkg::DV_DONE;
            end
         end
         tbbw_pkg::DV_DONE: begin
            state_in = tbbw_pkg::DV_IDLE;
         end
         default: begin
            state_in = tbbw_pkg::DV_IDLE;
         end
      endcase
      // a start always restarts, dropping any division in flight
      if (req.start) begin
         rem_in   = REM_W'(req.num);
         den_in   = req.den;
         state_in = tbbw_pkg::DV_SAT;
      end
   end

   assign rsp.done = (state_ff == tbbw_pkg::DV_DONE);
   assign rsp.quot = (quot_ff > tbbw_pkg::ONE_Q16) ? tbbw_pkg::ONE_Q16 : quot_ff;

endmodule

`default_nettype wire

FILE: rtl/tapered_block_bootstrap_weights.sv
// top level of the tapered block bootstrap frequency engine
`default_nettype none

// Tapered block bootstrap frequency engine. An add item (operation 0) places one
// resampled block of block_length observations starting at position: each covered
// entry gets its coverage count bumped and a trapezoid taper weight added in q1.16;
// a start beyond sample_count - block_length is rejected with bad_start and changes
// nothing. A read item (operation 1) returns the entry's count, weighted sum and the
// moving-block and tapered frequencies, then clears the entry. The block handles one
// item at a time and everything runs through a single divider (one compare-subtract,
// one quotient bit per cycle) and a single 32x29 multiplier. An add walks the block
// position by position: a weight check, a division on the taper ramps (none on the
// flat top of the trapezoid) and the store update. A read runs up to two divisions;
// a rejected add or a read outside the store goes straight to hand-over. A register
// write recomputes the window sum the same way as an add walk and the block stalls
// requests meanwhile. After reset a clearing pass sweeps every store entry before
// the first item is taken. A finished result waits in an output register, so a new
// item can be accepted while the previous result is still stalled.

module tapered_block_bootstrap_weights #(
   parameter int unsigned MAX_SAMPLES = tbbw_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration writes
   input  wire logic                              csr_write_en,
   input  wire logic [tbbw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tbbw_pkg::CSR_DATA_W-1:0]   csr_write_data,
   // request items
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_operation,
   input  wire logic [tbbw_pkg::POS_W-1:0]        req_position,
   // result items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [tbbw_pkg::CNT_W-1:0]             rsp_coverage_count,
   output logic [tbbw_pkg::SUM_W-1:0]             rsp_weighted_sum,
   output logic [tbbw_pkg::FREQ_W-1:0]            rsp_mbb_freq,
   output logic [tbbw_pkg::FREQ_W-1:0]            rsp_etbb_freq,
   output logic                                   rsp_bad_start
);

   // store address and a compare width that holds both the depth and pos + l
   localparam int unsigned AW    = $clog2(MAX_SAMPLES);
   localparam int unsigned DEPTH_W = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned MW    = (DEPTH_W > tbbw_pkg::LEN_W + 1) ? DEPTH_W
                                                                   : tbbw_pkg::LEN_W + 1;
   localparam logic [MW-1:0] MAX_M     = MW'(MAX_SAMPLES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SAMPLES - 1);
   localparam int unsigned ENT_W = tbbw_pkg::CNT_W + tbbw_pkg::SUM_W;

   // control
   tbbw_pkg::tbbw_state_type          state_ff, state_in;
   logic [tbbw_pkg::LEN_W-1:0]        n_ff, n_in;
   logic [tbbw_pkg::LEN_W-1:0]        l_ff, l_in;
   logic [tbbw_pkg::FRAC_W-1:0]       c_ff, c_in;
   logic [AW-1:0]                     clr_addr_ff, clr_addr_in;
   logic [tbbw_pkg::BLK_W-1:0]        blocks_ff, blocks_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [tbbw_pkg::DEN_W-1:0]        mul_ff, mul_in;
   logic [tbbw_pkg::LIM_W-1:0]        lim_ff, lim_in;
   logic [tbbw_pkg::LEN_W-1:0]        k_ff, k_in;
   logic [tbbw_pkg::FREQ_W-1:0]       w_ff, w_in;
   logic [tbbw_pkg::SUM_W-1:0]        window_ff, window_in;
   logic                              walk_add_ff, walk_add_in;
   logic [tbbw_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [tbbw_pkg::CNT_W-1:0]        cnt_res_ff, cnt_res_in;
   logic [tbbw_pkg::SUM_W-1:0]        ws_res_ff, ws_res_in;
   logic [tbbw_pkg::FREQ_W-1:0]       mbb_ff, mbb_in;
   logic [tbbw_pkg::FREQ_W-1:0]       etbb_ff, etbb_in;
   logic                              bad_ff, bad_in;

   // result register
   logic [tbbw_pkg::CNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;
   logic [tbbw_pkg::SUM_W-1:0]        rsp_ws_ff, rsp_ws_in;
   logic [tbbw_pkg::FREQ_W-1:0]       rsp_mbb_ff, rsp_mbb_in;
   logic [tbbw_pkg::FREQ_W-1:0]       rsp_etbb_ff, rsp_etbb_in;
   logic                              rsp_bad_ff, rsp_bad_in;

   // store of {count, weighted sum}
   logic [ENT_W-1:0]                  store_mem [MAX_SAMPLES];
   logic [ENT_W-1:0]                  rd_ff;
   logic                              mem_re;
   logic                              mem_we;
   logic [AW-1:0]                     mem_addr;
   logic [ENT_W-1:0]                  mem_wdata;

   // shared multiplier operands
   logic                              mul_en;
   logic [tbbw_pkg::BLK_W-1:0]        mul_a;
   logic [tbbw_pkg::SUM_W-1:0]        mul_b;

   // divider
   tbbw_pkg::div_req_type             div_req;
   tbbw_pkg::div_out_type             div_rsp;

   // datapath terms
   logic [tbbw_pkg::CNT_W-1:0]        rd_cnt;
   logic [tbbw_pkg::SUM_W-1:0]        rd_ws;
   logic [MW-1:0]                     idx_full;
   logic [MW-1:0]                     pos_full;
   logic [tbbw_pkg::LEN_W:0]          up_odd;
   logic [tbbw_pkg::LEN_W:0]          down_odd;
   logic [tbbw_pkg::LIM_W-1:0]        up_sh;
   logic [tbbw_pkg::LIM_W-1:0]        down_sh;
   logic [tbbw_pkg::LEN_W-1:0]        k_next;
   logic [tbbw_pkg::CNT_W-1:0]        cnt_next;
   logic [tbbw_pkg::SUM_W:0]          ws_sum;
   logic [tbbw_pkg::SUM_W-1:0]        ws_next;
   logic [tbbw_pkg::SUM_W:0]          win_sum;
   logic [tbbw_pkg::SUM_W-1:0]        win_next;
   logic                              add_bad;
   logic                              read_off;
   logic                              csr_known;

   tbbw_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // entry read back
   assign rd_cnt = rd_ff[ENT_W-1 -: tbbw_pkg::CNT_W];
   assign rd_ws  = rd_ff[tbbw_pkg::SUM_W-1:0];

   // current block position and taper terms 2k+1 and 2l-2k-1
   assign idx_full = MW'(pos_ff) + MW'(k_ff);
   assign pos_full = MW'(pos_ff);
   assign up_odd   = {k_ff, 1'b1};
   assign down_odd = {l_ff, 1'b0} - up_odd;
   assign up_sh    = {up_odd, {tbbw_pkg::FRAC_W{1'b0}}};
   assign down_sh  = {down_odd, {tbbw_pkg::FRAC_W{1'b0}}};
   assign k_next   = k_ff + 1'b1;

   // saturating updates
   assign cnt_next = (rd_cnt == tbbw_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
   assign ws_sum   = {1'b0, rd_ws} + (tbbw_pkg::SUM_W + 1)'(w_ff);
   assign ws_next  = (ws_sum > {1'b0, tbbw_pkg::SUM_MAX}) ? tbbw_pkg::SUM_MAX
                                                          : ws_sum[tbbw_pkg::SUM_W-1:0];
   assign win_sum  = {1'b0, window_ff} + (tbbw_pkg::SUM_W + 1)'(w_ff);
   assign win_next = (win_sum > {1'b0, tbbw_pkg::SUM_MAX}) ? tbbw_pkg::SUM_MAX
                                                           : win_sum[tbbw_pkg::SUM_W-1:0];

   // admission checks on the incoming item
   assign add_bad  = (MW'(n_ff) > MAX_M) || (l_ff == '0) || (l_ff > n_ff) ||
                     ((MW'(req_position) + MW'(l_ff)) > MW'(n_ff));
   assign read_off = (MW'(req_position) >= MAX_M);

   assign csr_known = (csr_index == tbbw_pkg::CSR_SAMPLE_COUNT) ||
                      (csr_index == tbbw_pkg::CSR_BLOCK_LENGTH) ||
                      (csr_index == tbbw_pkg::CSR_TAPER_FRACTION);

   assign req_stall = (state_ff != tbbw_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      l_in         = l_ff;
      c_in         = c_ff;
      clr_addr_in  = clr_addr_ff;
      blocks_in    = blocks_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      lim_in       = lim_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      window_in    = window_ff;
      walk_add_in  = walk_add_ff;
      pos_in       = pos_ff;
      cnt_res_in   = cnt_res_ff;
      ws_res_in    = ws_res_ff;
      mbb_in       = mbb_ff;
      etbb_in      = etbb_ff;
      bad_in       = bad_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_ws_in    = rsp_ws_ff;
      rsp_mbb_in   = rsp_mbb_ff;
      rsp_etbb_in  = rsp_etbb_ff;
      rsp_bad_in   = rsp_bad_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = idx_full[AW-1:0];
      mem_wdata    = '0;
      mul_en       = 1'b0;
      mul_a        = blocks_ff;
      mul_b        = tbbw_pkg::SUM_W'(l_ff);
      div_req      = '0;

      case (state_ff)
         // sweep the store to zero after reset
         tbbw_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = tbbw_pkg::ST_LMUL;
            end
         end
         // taper limit l*c, doubled in the next cycle
         tbbw_pkg::ST_LMUL: begin
            mul_en   = 1'b1;
            mul_a    = tbbw_pkg::BLK_W'(l_ff);
            mul_b    = tbbw_pkg::SUM_W'(c_ff);
            state_in = tbbw_pkg::ST_LSET;
         end
         tbbw_pkg::ST_LSET: begin
            lim_in      = {mul_ff[tbbw_pkg::LIM_W-2:0], 1'b0};
            window_in   = '0;
            k_in        = '0;
            walk_add_in = 1'b0;
            state_in    = (l_ff == '0) ? tbbw_pkg::ST_IDLE : tbbw_pkg::ST_WEVAL;
         end
         tbbw_pkg::ST_IDLE: begin
            if (req_valid) begin
               pos_in     = req_position;
               cnt_res_in = '0;
               ws_res_in  = '0;
               mbb_in     = '0;
               etbb_in    = '0;
               bad_in     = 1'b0;
               if (req_operation == tbbw_pkg::OP_ADD) begin
                  if (add_bad) begin
                     bad_in   = 1'b1;
                     state_in = tbbw_pkg::ST_OUT;
                  end else begin
                     walk_add_in = 1'b1;
                     k_in        = '0;
                     state_in    = tbbw_pkg::ST_WEVAL;
                  end
               end else begin
                  state_in = read_off ? tbbw_pkg::ST_OUT : tbbw_pkg::ST_RREAD;
               end
            end
         end
         // pick the taper segment: rising ramp, flat top or falling ramp
         tbbw_pkg::ST_WEVAL: begin
            mem_re = walk_add_ff;
            if (lim_ff == '0) begin
               w_in     = tbbw_pkg::ONE_Q16;
               state_in = tbbw_pkg::ST_WUSE;
            end else if (up_sh <= lim_ff) begin
               div_req.start = 1'b1;
               div_req.num   = up_sh;
               div_req.den   = tbbw_pkg::DEN_W'(lim_ff);
               state_in      = tbbw_pkg::ST_WDIV;
            end else if (down_sh > lim_ff) begin
               w_in     = tbbw_pkg::ONE_Q16;
               state_in = tbbw_pkg::ST_WUSE;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = down_sh;
               div_req.den   = tbbw_pkg::DEN_W'(lim_ff);
               state_in      = tbbw_pkg::ST_WDIV;
            end
         end
         tbbw_pkg::ST_WDIV: begin
            if (div_rsp.done) begin
               w_in     = div_rsp.quot;
               state_in = tbbw_pkg::ST_WUSE;
            end
         end
         // apply the weight to the store entry or to the window sum
         tbbw_pkg::ST_WUSE: begin
            k_in = k_next;
            if (walk_add_ff) begin
               mem_we    = 1'b1;
               mem_wdata = {cnt_next, ws_next};
            end else begin
               window_in = win_next;
            end
            if (k_next == l_ff) begin
               if (walk_add_ff) begin
                  blocks_in = (blocks_ff == '1) ? blocks_ff : blocks_ff + 1'b1;
                  state_in  = tbbw_pkg::ST_OUT;
               end else begin
                  state_in = tbbw_pkg::ST_IDLE;
               end
            end else begin
               state_in = tbbw_pkg::ST_WEVAL;
            end
         end
         // read the entry and clear it in the same cycle
         tbbw_pkg::ST_RREAD: begin
            mem_re   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = pos_full[AW-1:0];
            mul_en   = 1'b1;
            state_in = tbbw_pkg::ST_RDEN;
         end
         // count over blocks*l; blocks*window_sum is formed meanwhile
         tbbw_pkg::ST_RDEN: begin
            cnt_res_in = rd_cnt;
            ws_res_in  = rd_ws;
            mul_en     = 1'b1;
            mul_b      = window_ff;
            if (mul_ff != '0) begin
               div_req.start = 1'b1;
               div_req.num   = tbbw_pkg::NUM_W'(rd_cnt);
               div_req.den   = mul_ff;
               state_in      = tbbw_pkg::ST_RDIV1;
            end else begin
               state_in = tbbw_pkg::ST_RDEN2;
            end
         end
         tbbw_pkg::ST_RDIV1: begin
            if (div_rsp.done) begin
               mbb_in   = div_rsp.quot;
               state_in = tbbw_pkg::ST_RDEN2;
            end
         end
         tbbw_pkg::ST_RDEN2: begin
            if (mul_ff != '0) begin
               div_req.start = 1'b1;
               div_req.num   = tbbw_pkg::NUM_W'(ws_res_ff);
               div_req.den   = mul_ff;
               state_in      = tbbw_pkg::ST_RDIV2;
            end else begin
               state_in = tbbw_pkg::ST_OUT;
            end
         end
         tbbw_pkg::ST_RDIV2: begin
            if (div_rsp.done) begin
               etbb_in  = div_rsp.quot;
               state_in = tbbw_pkg::ST_OUT;
            end
         end
         // hand the item over once the result register is free
         tbbw_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = cnt_res_ff;
               rsp_ws_in    = ws_res_ff;
               rsp_mbb_in   = mbb_ff;
               rsp_etbb_in  = etbb_ff;
               rsp_bad_in   = bad_ff;
               state_in     = tbbw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbbw_pkg::ST_IDLE;
         end
      endcase

      // register writes; a known register restarts the window sum
      if (csr_write_en) begin
         case (csr_index)
            tbbw_pkg::CSR_SAMPLE_COUNT:   n_in = csr_write_data[tbbw_pkg::LEN_W-1:0];
            tbbw_pkg::CSR_BLOCK_LENGTH:   l_in = csr_write_data[tbbw_pkg::LEN_W-1:0];
            tbbw_pkg::CSR_TAPER_FRACTION: c_in = csr_write_data;
            default:                      n_in = n_ff;
         endcase
         if (csr_known && (state_ff != tbbw_pkg::ST_CLEAR)) begin
            state_in = tbbw_pkg::ST_LMUL;
         end
      end
   end

   always_comb begin
      mul_in = mul_ff;
      if (mul_en) begin
         mul_in = tbbw_pkg::DEN_W'(mul_a) * tbbw_pkg::DEN_W'(mul_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbbw_pkg::ST_CLEAR;
         n_ff         <= tbbw_pkg::SAMPLE_COUNT_RST;
         l_ff         <= tbbw_pkg::BLOCK_LENGTH_RST;
         c_ff         <= tbbw_pkg::TAPER_FRACTION_RST;
         clr_addr_ff  <= '0;
         blocks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         l_ff         <= l_in;
         c_ff         <= c_in;
         clr_addr_ff  <= clr_addr_in;
         blocks_ff    <= blocks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff      <= mul_in;
      lim_ff      <= lim_in;
      k_ff        <= k_in;
      w_ff        <= w_in;
      window_ff   <= window_in;
      walk_add_ff <= walk_add_in;
      pos_ff      <= pos_in;
      cnt_res_ff  <= cnt_res_in;
      ws_res_ff   <= ws_res_in;
      mbb_ff      <= mbb_in;
      etbb_ff     <= etbb_in;
      bad_ff      <= bad_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_ws_ff   <= rsp_ws_in;
      rsp_mbb_ff  <= rsp_mbb_in;
      rsp_etbb_ff <= rsp_etbb_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // store: read-first, so a read and its clear happen in the same cycle
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_ff <= store_mem[mem_addr];
      end
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_coverage_count = rsp_cnt_ff;
   assign rsp_weighted_sum   = rsp_ws_ff;
   assign rsp_mbb_freq       = rsp_mbb_ff;
   assign rsp_etbb_freq      = rsp_etbb_ff;
   assign rsp_bad_start      = rsp_bad_ff;

   // a result only appears from the hand-over state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tbbw_pkg::ST_OUT))
      else $error("result raised outside hand-over");

   // a rejected add carries no counts or frequencies
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_cnt_ff == '0 && rsp_ws_ff == '0 &&
                                        rsp_mbb_ff == '0 && rsp_etbb_ff == '0))
      else $error("rejected add with nonzero fields");

   // frequencies are saturated at one
   a_freq_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_mbb_ff <= tbbw_pkg::ONE_Q16 &&
                        rsp_etbb_ff <= tbbw_pkg::ONE_Q16))
      else $error("frequency above one");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while busy");

   // the window sum only moves while it is being recomputed
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbbw_pkg::ST_IDLE) |=> $stable(window_ff))
      else $error("window sum changed while idle");

endmodule

`default_nettype wire

FILE: test/bootstrap_freq_checker.sv
// mirror of the bootstrap frequency engine that predicts and compares its result items
`timescale 1ns / 100ps

module bootstrap_freq_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [tbbw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tbbw_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic                            req_operation,
   input  wire logic [tbbw_pkg::POS_W-1:0]      req_position,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [tbbw_pkg::CNT_W-1:0]      rsp_coverage_count,
   input  wire logic [tbbw_pkg::SUM_W-1:0]      rsp_weighted_sum,
   input  wire logic [tbbw_pkg::FREQ_W-1:0]     rsp_mbb_freq,
   input  wire logic [tbbw_pkg::FREQ_W-1:0]     rsp_etbb_freq,
   input  wire logic                            rsp_bad_start,
   output int unsigned                          mismatches,
   output int unsigned                          owed
);
   import tbbw_pkg::*;

   localparam int unsigned DEPTH = MAX_SAMPLES_DEF;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [SUM_W-1:0]  wsum;
      logic [FREQ_W-1:0] mbb;
      logic [FREQ_W-1:0] etbb;
      logic              bad;
   } tally_t;

   tally_t tally_queue[$];

   logic [CNT_W-1:0]  cover_mirror [DEPTH];
   logic [SUM_W-1:0]  wsum_mirror [DEPTH];
   logic [LEN_W-1:0]  n_reg;
   logic [LEN_W-1:0]  l_reg;
   logic [FRAC_W-1:0] c_reg;
   logic [SUM_W-1:0]  window_total;
   logic [BLK_W-1:0]  block_total;

   // trapezoid weight in q1.16, exact integer form with L = 2*l*c
   function automatic logic [FREQ_W-1:0] taper_weight(input int unsigned k,
                                                      input int unsigned l,
                                                      input int unsigned c);
      longint unsigned lim;
      longint unsigned up;
      longint unsigned down;
      longint unsigned w;
      lim  = 2 * longint'(l) * c;
      up   = 2 * longint'(k) + 1;
      down = (2 * longint'(l) >= up) ? 2 * longint'(l) - up : 0;
      if (up * ONE_Q16 <= lim)
         w = (lim != 0) ? (up << 32) / lim : ONE_Q16;
      else if (down * ONE_Q16 > lim)
         w = ONE_Q16;
      else
         w = (lim != 0) ? (down << 32) / lim : ONE_Q16;
      if (w > ONE_Q16)
         w = ONE_Q16;
      return w[FREQ_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] window_of(input int unsigned l, input int unsigned c);
      longint unsigned acc;
      acc = 0;
      for (int unsigned k = 0; k < l; k++) begin
         acc += taper_weight(k, l, c);
         if (acc > SUM_MAX) begin
            acc = SUM_MAX;
            break;
         end
      end
      return acc[SUM_W-1:0];
   endfunction

   function automatic logic [FREQ_W-1:0] freq_of(input longint unsigned num,
                                                 input longint unsigned den,
                                                 input logic [BLK_W-1:0] blocks);
      longint unsigned q;
      if (blocks == 0 || den == 0)
         return '0;
      q = (num * ONE_Q16) / den;
      if (q > ONE_Q16)
         q = ONE_Q16;
      return q[FREQ_W-1:0];
   endfunction

   // updates the mirror for one accepted item and returns its result
   function automatic tally_t apply_item(input logic op, input logic [POS_W-1:0] pos);
      tally_t          r;
      int unsigned     n;
      int unsigned     l;
      int unsigned     idx;
      longint unsigned s;
      longint unsigned den;
      logic [FREQ_W-1:0] w;
      r = '0;
      n = n_reg;
      l = l_reg;
      if (op == OP_ADD) begin
         if (n > DEPTH || l == 0 || l > n || pos > n - l) begin
            r.bad = 1'b1;
         end else begin
            for (int unsigned k = 0; k < l; k++) begin
               idx = pos + k;
               w = taper_weight(k, l, c_reg);
               s = longint'(wsum_mirror[idx]) + w;
               if (cover_mirror[idx] != COUNT_MAX)
                  cover_mirror[idx] = cover_mirror[idx] + 1'b1;
               wsum_mirror[idx] = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
            end
            if (block_total != '1)
               block_total = block_total + 1'b1;
         end
      end else begin
         r.count = cover_mirror[pos];
         r.wsum  = wsum_mirror[pos];
         den = block_total;
         r.mbb = freq_of(r.count, den * l_reg, block_total);
         r.etbb = freq_of(r.wsum, den * window_total, block_total);
         cover_mirror[pos] = '0;
         wsum_mirror[pos]  = '0;
      end
      return r;
   endfunction

   task automatic check_field(input string field, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      tally_t want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            cover_mirror[i] = '0;
            wsum_mirror[i]  = '0;
         end
         n_reg = SAMPLE_COUNT_RST;
         l_reg = BLOCK_LENGTH_RST;
         c_reg = TAPER_FRACTION_RST;
         window_total = window_of(l_reg, c_reg);
         block_total = '0;
         tally_queue.delete();
         mismatches = 0;
         owed <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SAMPLE_COUNT:   n_reg = csr_write_data[LEN_W-1:0];
               CSR_BLOCK_LENGTH:   l_reg = csr_write_data[LEN_W-1:0];
               CSR_TAPER_FRACTION: c_reg = csr_write_data[FRAC_W-1:0];
               default: ;
            endcase
            window_total = window_of(l_reg, c_reg);
         end
         if (rsp_valid && !rsp_stall) begin
            if (tally_queue.size() == 0) begin
               $error("result item with none outstanding");
               mismatches++;
            end else begin
               want = tally_queue.pop_front();
               check_field("coverage_count", want.count, rsp_coverage_count);
               check_field("weighted_sum", want.wsum, rsp_weighted_sum);
               check_field("mbb_freq", want.mbb, rsp_mbb_freq);
               check_field("etbb_freq", want.etbb, rsp_etbb_freq);
               check_field("bad_start", want.bad, rsp_bad_start);
            end
         end
         if (req_valid && !req_stall)
            tally_queue.push_back(apply_item(req_operation, req_position));
         owed <= tally_queue.size();
      end
   end

endmodule

FILE: test/testbench.sv
// top of the bootstrap frequency engine testbench: stimulus, settings and verdict
`timescale 1ns / 100ps

module testbench;
   import tbbw_pkg::*;

   localparam int unsigned ITEM_GOAL   = 1300;
   localparam int unsigned CALM_AFTER  = 1150;
   // longest quiet stretch is a full-length window walk
   localparam int unsigned QUIET_LIMIT = 400000;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = CSR_SAMPLE_COUNT;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_operation  = OP_ADD;
   logic [POS_W-1:0]      req_position   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [CNT_W-1:0]      rsp_coverage_count;
   logic [SUM_W-1:0]      rsp_weighted_sum;
   logic [FREQ_W-1:0]     rsp_mbb_freq;
   logic [FREQ_W-1:0]     rsp_etbb_freq;
   logic                  rsp_bad_start;

   int unsigned mismatches;
   int unsigned owed;
   int unsigned items_sent   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_left   = 0;
   int unsigned cur_l        = BLOCK_LENGTH_RST;
   int unsigned last_start   = 0;
   logic        calm         = 1'b0;

   tapered_block_bootstrap_weights u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_coverage_count (rsp_coverage_count),
      .rsp_weighted_sum   (rsp_weighted_sum),
      .rsp_mbb_freq       (rsp_mbb_freq),
      .rsp_etbb_freq      (rsp_etbb_freq),
      .rsp_bad_start      (rsp_bad_start)
   );

   bootstrap_freq_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_coverage_count (rsp_coverage_count),
      .rsp_weighted_sum   (rsp_weighted_sum),
      .rsp_mbb_freq       (rsp_mbb_freq),
      .rsp_etbb_freq      (rsp_etbb_freq),
      .rsp_bad_start      (rsp_bad_start),
      .mismatches         (mismatches),
      .owed               (owed)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side back-pressure: random bursts of stalled cycles
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles where no item moves and no register is written
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one item, maybe after a short idle burst, and hold it until taken
   task automatic offer_item(input logic op, input logic [POS_W-1:0] pos);
      int unsigned gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // stop sending and wait for every outstanding result item
   task automatic drain();
      req_valid <= 1'b0;
      // owed is registered, so it lags acceptance
      @(posedge clock);
      while (owed != 0) @(posedge clock);
   endtask

   // one register write, then room for the window sum walk it triggers
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_index      <= idx;
      csr_write_data <= value[CSR_DATA_W-1:0];
      csr_write_en   <= 1'b1;
      if (idx == CSR_BLOCK_LENGTH)
         cur_l = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      repeat (16 + 24 * cur_l) @(posedge clock);
   endtask

   // new settings, only with the engine idle
   task automatic configure(input int unsigned n, input int unsigned l, input int unsigned c);
      drain();
      repeat (4) @(posedge clock);
      // shrink the block first so the other writes do not walk a long window
      if (cur_l > 64)
         write_reg(CSR_BLOCK_LENGTH, 1);
      write_reg(CSR_SAMPLE_COUNT, n);
      write_reg(CSR_TAPER_FRACTION, c);
      write_reg(CSR_BLOCK_LENGTH, l);
   endtask

   // one random setting followed by a burst of mostly well-formed adds and nearby reads
   task automatic random_phase();
      int unsigned n;
      int unsigned l;
      int unsigned c;
      int unsigned count;
      int unsigned pick;
      logic        wide;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         n = 2;
      else if (pick == 1)
         n = 4096;
      else if (pick < 6)
         n = $urandom_range(2, 64);
      else
         n = $urandom_range(2, 4096);
      // a few phases with long blocks, most with short ones to keep the run fast
      wide = ($urandom_range(0, 9) == 0);
      l = wide ? $urandom_range(50, 300) : $urandom_range(1, 16);
      if (l > n)
         l = n;
      // block longer than the series: every add is rejected
      if (n < 4096 && $urandom_range(0, 9) == 0) begin
         l = n + $urandom_range(1, 3);
         if (l > 4096)
            l = 4096;
      end
      pick = $urandom_range(0, 3);
      c = (pick == 0) ? 1 : (pick == 1) ? 32768 : $urandom_range(1, 32768);
      configure(n, l, c);
      calm = (items_sent >= CALM_AFTER) || ($urandom_range(0, 5) == 0);
      count = wide ? $urandom_range(6, 12) : $urandom_range(40, 120);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55 && l <= n) begin
            last_start = $urandom_range(0, n - l);
            offer_item(OP_ADD, last_start);
         end else if (pick < 62) begin
            // arbitrary start, often past n - l
            offer_item(OP_ADD, $urandom_range(0, 4095));
         end else if (pick < 90) begin
            // read inside the most recent block
            offer_item(OP_READ, (last_start + $urandom_range(0, l - 1)) % 4096);
         end else begin
            offer_item(OP_READ, $urandom_range(0, 4095));
         end
         // now and then let every result come home before going on
         if ($urandom_range(0, 39) == 0)
            drain();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: whole store, unit block, taper one half
      // reads before any add give zero frequencies
      offer_item(OP_READ, 0);
      offer_item(OP_READ, 4095);
      offer_item(OP_ADD, 0);
      offer_item(OP_ADD, 4095);
      offer_item(OP_READ, 0);
      offer_item(OP_READ, 4095);
      // entry 0 was cleared by the earlier read of it
      offer_item(OP_READ, 0);

      // shortest series, narrowest taper
      configure(2, 2, 1);
      offer_item(OP_ADD, 0);
      offer_item(OP_ADD, 1);
      offer_item(OP_ADD, 4095);
      offer_item(OP_READ, 1);
      // read beyond the series still returns the stored entry
      offer_item(OP_READ, 4095);

      // block longer than the series
      configure(2, 3, 1);
      offer_item(OP_ADD, 0);
      offer_item(OP_READ, 0);

      // longest block with the widest taper: every position needs a division
      configure(4096, 4096, 32768);
      offer_item(OP_ADD, 0);
      offer_item(OP_ADD, 1);
      offer_item(OP_READ, 0);
      offer_item(OP_READ, 2048);
      offer_item(OP_READ, 4095);

      while (items_sent < ITEM_GOAL)
         random_phase();

      drain();
      // output register and last read division
      repeat (64) @(posedge clock);
      if (mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/tbbw_pkg.sv
rtl/tbbw_div.sv
rtl/tapered_block_bootstrap_weights.sv
test/bootstrap_freq_checker.sv
test/testbench.sv
